FILE: rtl/core/lgsc_pkg.sv
`timescale 1ns / 1ps

package lgsc_pkg;

  // Default sizing of the top level.
  localparam int DEF_MAX_SAMPLES = 4096;
  localparam int DEF_GRAD_BITS   = 12;
  localparam int DEF_COORD_BITS  = 13;

  // Fixed field and state widths.
  localparam int SUM_W       = 40;
  localparam int MEAN_W      = 16;
  localparam int MING_W      = 16;
  localparam int RATIO_W     = 9;
  localparam int RATIO_SHIFT = 8;
  localparam int SEEN_W      = 13;
  localparam int FRAC_BITS   = 4;
  localparam int QUEUE_DEPTH = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GRADIENT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LOW_RATIO = 1'd1;

  localparam logic [MING_W-1:0]  MIN_GRADIENT_RST  = '0;
  localparam logic [RATIO_W-1:0] MAX_LOW_RATIO_RST = 9'd64;

  typedef struct packed {
    logic [MEAN_W-1:0] mean;
    logic              accepted;
    logic              zero_length;
    logic [SEEN_W-1:0] seen;
  } result_t;

endpackage

FILE: rtl/core/lgsc_queue.sv
`timescale 1ns / 1ps

module lgsc_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         not_empty
);
  import lgsc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]     mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign dout      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/core/lgsc_front.sv
`timescale 1ns / 1ps

module lgsc_front #(
  parameter int GRAD_BITS   = 12,
  parameter int COORD_BITS  = 13,
  parameter int MAX_SAMPLES = 4096,
  parameter int CNT_W       = 13,
  parameter int D2_W        = 26,
  parameter int REC_W       = 104
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [GRAD_BITS-1:0]   in_grad_x,
  input  logic signed [GRAD_BITS-1:0]   in_grad_y,
  input  logic signed [COORD_BITS-1:0]  in_line_dx,
  input  logic signed [COORD_BITS-1:0]  in_line_dy,
  input  logic                          in_last_sample,
  input  logic signed [lgsc_pkg::MING_W-1:0] min_gradient,
  output logic                          rec_valid,
  output logic [REC_W-1:0]              rec,
  input  logic                          rec_ready
);
  import lgsc_pkg::*;

  localparam int R_W   = GRAD_BITS + COORD_BITS + 1;
  localparam int P_W   = GRAD_BITS + COORD_BITS;
  localparam int A_W   = R_W + FRAC_BITS;
  localparam int SQ_W  = 2 * A_W;
  localparam int M2_W  = 2 * MING_W;
  localparam int RHS_W = M2_W + D2_W;
  localparam int CMP_W = (SQ_W > RHS_W) ? SQ_W : RHS_W;
  localparam logic signed [SUM_W:0] SUM_HI = (SUM_W+1)'((64'sd1 <<< (SUM_W - 1)) - 1);
  localparam logic signed [SUM_W:0] SUM_LO = -SUM_HI - (SUM_W+1)'(1);

  typedef enum logic [3:0] {
    F_IDLE, F_DX2, F_DY2, F_M2, F_RHS, F_P1, F_P2, F_SQ, F_UPD
  } fstate_t;

  fstate_t                  state_r;
  logic signed [GRAD_BITS-1:0]  gx_r;
  logic signed [GRAD_BITS-1:0]  gy_r;
  logic                     last_r;
  logic signed [COORD_BITS-1:0] hdx_r;
  logic signed [COORD_BITS-1:0] hdy_r;
  logic [D2_W-1:0]          dxx_r;
  logic [D2_W-1:0]          d2_r;
  logic [M2_W-1:0]          mm2_r;
  logic [RHS_W-1:0]         rhs_r;
  logic signed [P_W-1:0]    p1_r;
  logic signed [R_W-1:0]    r_r;
  logic [SQ_W-1:0]          lhs_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]         low_r;
  logic [CNT_W-1:0]         total_r;

  logic signed [2*COORD_BITS-1:0] sq_c;
  logic [MING_W-1:0]        mm;
  logic signed [P_W-1:0]    prod_g;
  logic [R_W-1:0]           r_abs;
  logic [A_W-1:0]           amag;
  logic signed [SUM_W:0]    ns;
  logic signed [SUM_W-1:0]  sum_new;
  logic                     is_low;
  logic [CNT_W-1:0]         low_new;
  logic [CNT_W-1:0]         total_inc;
  logic                     emit;
  logic                     line_ok;

  // Operand selection for the squaring steps and the two gradient products.
  always_comb begin
    sq_c   = (state_r == F_DX2) ? hdx_r * hdx_r : hdy_r * hdy_r;
    prod_g = (state_r == F_P1) ? gy_r * hdx_r : gx_r * hdy_r;
  end

  assign mm    = min_gradient[MING_W-1] ? MING_W'(-min_gradient) : MING_W'(min_gradient);
  assign r_abs = r_r[R_W-1] ? R_W'(-r_r) : R_W'(r_r);
  assign amag  = {r_abs, {FRAC_BITS{1'b0}}};

  always_comb begin
    if (!r_r[R_W-1]) begin
      is_low = (min_gradient > 0) && (CMP_W'(lhs_r) < CMP_W'(rhs_r));
    end else begin
      is_low = (min_gradient >= 0) || (CMP_W'(lhs_r) > CMP_W'(rhs_r));
    end
    line_ok = (d2_r != '0);
    ns = (SUM_W+1)'(sum_r) + (SUM_W+1)'(r_r);
    if (!line_ok) begin
      sum_new = sum_r;
    end else if (ns > SUM_HI) begin
      sum_new = SUM_W'(SUM_HI);
    end else if (ns < SUM_LO) begin
      sum_new = SUM_W'(SUM_LO);
    end else begin
      sum_new = SUM_W'(ns);
    end
    low_new   = (line_ok && is_low) ? low_r + CNT_W'(1) : low_r;
    total_inc = total_r + CNT_W'(1);
    emit      = last_r || (total_inc == CNT_W'(MAX_SAMPLES));
  end

  assign in_ready  = (state_r == F_IDLE);
  assign rec_valid = (state_r == F_UPD) && emit;
  assign rec       = {sum_new, low_new, total_inc, d2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      sum_r   <= '0;
      low_r   <= '0;
      total_r <= '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            gx_r   <= in_grad_x;
            gy_r   <= in_grad_y;
            last_r <= in_last_sample;
            if (total_r == '0) begin
              hdx_r   <= in_line_dx;
              hdy_r   <= in_line_dy;
              state_r <= F_DX2;
            end else begin
              state_r <= F_P1;
            end
          end
        end
        F_DX2: begin
          dxx_r   <= D2_W'(unsigned'(sq_c));
          state_r <= F_DY2;
        end
        F_DY2: begin
          d2_r    <= dxx_r + D2_W'(unsigned'(sq_c));
          state_r <= F_M2;
        end
        F_M2: begin
          mm2_r   <= M2_W'(mm * mm);
          state_r <= F_RHS;
        end
        F_RHS: begin
          rhs_r   <= RHS_W'(mm2_r * d2_r);
          state_r <= F_P1;
        end
        F_P1: begin
          p1_r    <= prod_g;
          state_r <= F_P2;
        end
        F_P2: begin
          r_r     <= R_W'(p1_r) - R_W'(prod_g);
          state_r <= F_SQ;
        end
        F_SQ: begin
          lhs_r   <= SQ_W'(amag * amag);
          state_r <= F_UPD;
        end
        F_UPD: begin
          if (!emit) begin
            sum_r   <= sum_new;
            low_r   <= low_new;
            total_r <= total_inc;
            state_r <= F_IDLE;
          end else if (rec_ready) begin
            sum_r   <= '0;
            low_r   <= '0;
            total_r <= '0;
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/lgsc_mul.sv
`timescale 1ns / 1ps

module lgsc_mul #(
  parameter int MUL_W = 52
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [MUL_W-1:0]   a,
  input  logic [MUL_W-1:0]   b,
  output logic               done,
  output logic [2*MUL_W-1:0] prod
);
  import lgsc_pkg::*;

  localparam int CNT_W = $clog2(MUL_W);

  logic [MUL_W-1:0] a_r;
  logic [MUL_W-1:0] hi_r;
  logic [MUL_W-1:0] lo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;
  logic [MUL_W:0]   psum;

  // Shift-and-add, one multiplier bit per cycle.
  assign psum = {1'b0, hi_r} + {1'b0, (lo_r[0] ? a_r : '0)};
  assign done = done_r;
  assign prod = {hi_r, lo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r   <= a;
        lo_r  <= b;
        hi_r  <= '0;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        hi_r  <= psum[MUL_W:1];
        lo_r  <= {psum[0], lo_r[MUL_W-1:1]};
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(MUL_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/lgsc_back.sv
`timescale 1ns / 1ps

module lgsc_back #(
  parameter int CNT_W = 13,
  parameter int D2_W  = 26,
  parameter int REC_W = 104
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rec_valid,
  input  logic [REC_W-1:0]              rec,
  output logic                          rec_pop,
  input  logic [lgsc_pkg::RATIO_W-1:0]  max_low_ratio,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lgsc_pkg::result_t             out_res
);
  import lgsc_pkg::*;

  localparam int K_W   = 2 * CNT_W + D2_W;
  localparam int SM_W  = SUM_W + FRAC_BITS + 1;
  localparam int TT_W  = MEAN_W + 1;
  localparam int U_W   = 2 * TT_W;
  localparam int W1    = (K_W > SM_W) ? K_W : SM_W;
  localparam int MUL_W = (W1 > U_W) ? W1 : U_W;
  localparam int REM_W = $clog2(MEAN_W + 1);
  localparam int BIT_W = $clog2(MEAN_W);
  localparam logic [MEAN_W-1:0] POS_MAX = MEAN_W'((1 << (MEAN_W - 1)) - 1);
  localparam logic [MEAN_W-1:0] NEG_MAX = MEAN_W'(1 << (MEAN_W - 1));

  typedef enum logic [2:0] {
    B_IDLE, B_RATIO, B_LAUNCH, B_WAIT, B_SEARCH, B_OUT
  } bstate_t;

  typedef enum logic [2:0] {OP_N2, OP_K, OP_T, OP_U, OP_L} op_t;

  bstate_t                 state_r;
  op_t                     op_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0]        low_r;
  logic [CNT_W-1:0]        total_r;
  logic [D2_W-1:0]         d2_r;
  logic [2*CNT_W-1:0]      n2_r;
  logic [K_W-1:0]          k_r;
  logic [2*MUL_W-1:0]      t_r;
  logic [U_W-1:0]          u_r;
  logic [MEAN_W-1:0]       c_r;
  logic [MEAN_W-1:0]       cand_r;
  logic [REM_W-1:0]        rem_r;
  logic                    out_valid_r;
  result_t                 out_r;

  logic                    mul_start;
  logic [MUL_W-1:0]        mul_a;
  logic [MUL_W-1:0]        mul_b;
  logic                    mul_done;
  logic [2*MUL_W-1:0]      mul_p;
  logic [SUM_W-1:0]        sum_abs;
  logic [SM_W-1:0]         sm;
  logic [TT_W-1:0]         tval;
  logic [MEAN_W-1:0]       hi_lim;
  logic [BIT_W-1:0]        bit_idx;
  logic [MEAN_W-1:0]       cand;
  logic                    ratio_ok;
  logic                    zero_len;
  logic                    neg;

  assign neg      = sum_r[SUM_W-1];
  assign sum_abs  = neg ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign sm       = {sum_abs, {(FRAC_BITS + 1){1'b0}}};
  assign tval     = {cand_r, 1'b0} - TT_W'(1);
  assign hi_lim   = neg ? NEG_MAX : POS_MAX;
  assign bit_idx  = BIT_W'(rem_r - REM_W'(1));
  assign cand     = c_r | (MEAN_W'(1) << bit_idx);
  assign zero_len = (d2_r == '0);
  assign ratio_ok = (({low_r, {RATIO_SHIFT{1'b0}}}) <=
                     (CNT_W + RATIO_W)'(max_low_ratio * total_r));

  always_comb begin
    unique case (op_r)
      OP_N2: begin
        mul_a = MUL_W'(total_r);
        mul_b = MUL_W'(total_r);
      end
      OP_K: begin
        mul_a = MUL_W'(n2_r);
        mul_b = MUL_W'(d2_r);
      end
      OP_T: begin
        mul_a = MUL_W'(sm);
        mul_b = MUL_W'(sm);
      end
      OP_U: begin
        mul_a = MUL_W'(tval);
        mul_b = MUL_W'(tval);
      end
      OP_L: begin
        mul_a = MUL_W'(u_r);
        mul_b = MUL_W'(k_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_start = (state_r == B_LAUNCH);
  assign rec_pop   = (state_r == B_IDLE) && rec_valid;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  lgsc_mul #(.MUL_W(MUL_W)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      op_r        <= OP_N2;
      out_valid_r <= 1'b0;
    end else begin
      // B_OUT reloads the output register itself when it frees up.
      if (out_valid_r && out_ready && (state_r != B_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (rec_valid) begin
            {sum_r, low_r, total_r, d2_r} <= rec;
            c_r     <= '0;
            rem_r   <= REM_W'(MEAN_W);
            state_r <= B_RATIO;
          end
        end
        B_RATIO: begin
          if (!zero_len && ratio_ok) begin
            op_r    <= OP_N2;
            state_r <= B_LAUNCH;
          end else begin
            state_r <= B_OUT;
          end
        end
        B_LAUNCH: begin
          state_r <= B_WAIT;
        end
        B_WAIT: begin
          if (mul_done) begin
            unique case (op_r)
              OP_N2: begin
                n2_r    <= (2*CNT_W)'(mul_p);
                op_r    <= OP_K;
                state_r <= B_LAUNCH;
              end
              OP_K: begin
                k_r     <= K_W'(mul_p);
                op_r    <= OP_T;
                state_r <= B_LAUNCH;
              end
              OP_T: begin
                t_r     <= mul_p;
                state_r <= B_SEARCH;
              end
              OP_U: begin
                u_r     <= U_W'(mul_p);
                op_r    <= OP_L;
                state_r <= B_LAUNCH;
              end
              OP_L: begin
                if (mul_p <= t_r) begin
                  c_r <= cand_r;
                end
                rem_r   <= rem_r - REM_W'(1);
                state_r <= B_SEARCH;
              end
              default: state_r <= B_SEARCH;
            endcase
          end
        end
        B_SEARCH: begin
          if (rem_r == '0) begin
            state_r <= B_OUT;
          end else if (cand > hi_lim) begin
            rem_r <= rem_r - REM_W'(1);
          end else begin
            cand_r  <= cand;
            op_r    <= OP_U;
            state_r <= B_LAUNCH;
          end
        end
        B_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_r.mean        <= neg ? MEAN_W'(-c_r) : c_r;
            out_r.accepted    <= !zero_len && ratio_ok;
            out_r.zero_length <= zero_len;
            out_r.seen        <= SEEN_W'(total_r);
            out_valid_r       <= 1'b1;
            state_r           <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/line_gradient_support_check_core.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake          | Payload
// in_      | input     | in_valid/in_ready  | grad_x, grad_y, line_dx, line_dy, last_sample
// out_     | output    | out_valid/out_ready| mean_gradient, accepted, zero_length, samples_seen
// cfg_     | input     | cfg_we             | cfg_index, cfg_data
//
// The front takes a new sample only after the last one has passed the accepting
// state and four sequencer steps (two gradient products, the squared normal
// component and the update). The first sample of a line also passes
// through the steps that square the endpoint difference and form the threshold
// square; a line end waits in the update step while the queue is full.
// A line whose low ratio passes goes through up to 35 serial multiplies in the
// back; a rejected or zero-length line goes from the ratio test straight to the
// output state. A two-entry queue of line records lets the front keep taking
// samples while the back works.
// Reset is synchronous and active low; it clears the line state and the queue.
// The result sits in an output register, so a stalled result transfer blocks
// the back only when another finished line wants that register.

module line_gradient_support_check_core #(
  parameter int MAX_SAMPLES = lgsc_pkg::DEF_MAX_SAMPLES,
  parameter int GRAD_BITS   = lgsc_pkg::DEF_GRAD_BITS,
  parameter int COORD_BITS  = lgsc_pkg::DEF_COORD_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lgsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lgsc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [GRAD_BITS-1:0]       in_grad_x,
  input  logic signed [GRAD_BITS-1:0]       in_grad_y,
  input  logic signed [COORD_BITS-1:0]      in_line_dx,
  input  logic signed [COORD_BITS-1:0]      in_line_dy,
  input  logic                              in_last_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [lgsc_pkg::MEAN_W-1:0] out_mean_gradient,
  output logic                              out_accepted,
  output logic                              out_zero_length,
  output logic [lgsc_pkg::SEEN_W-1:0]       out_samples_seen
);
  import lgsc_pkg::*;

  // Counter wide enough to hold MAX_SAMPLES itself.
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  // Squared endpoint length.
  localparam int D2_W  = 2 * COORD_BITS;
  // One line record: saturated sum, low count, sample count, squared length.
  localparam int REC_W = SUM_W + 2 * CNT_W + D2_W;

  logic signed [MING_W-1:0] min_gradient_r;
  logic [RATIO_W-1:0]       max_low_ratio_r;

  logic             fr_valid;
  logic [REC_W-1:0] fr_rec;
  logic             q_full;
  logic             q_not_empty;
  logic [REC_W-1:0] q_dout;
  logic             bk_pop;
  result_t          res;

  // Configuration registers; the user must write them only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_gradient_r  <= MIN_GRADIENT_RST;
      max_low_ratio_r <= MAX_LOW_RATIO_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_GRADIENT:  min_gradient_r  <= cfg_data[MING_W-1:0];
        REG_MAX_LOW_RATIO: max_low_ratio_r <= cfg_data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: takes each sample, forms the normal component, accumulates the
  // saturated sum and the low-sample count, and closes out a line record.
  lgsc_front #(
    .GRAD_BITS   (GRAD_BITS),
    .COORD_BITS  (COORD_BITS),
    .MAX_SAMPLES (MAX_SAMPLES),
    .CNT_W       (CNT_W),
    .D2_W        (D2_W),
    .REC_W       (REC_W)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_grad_x      (in_grad_x),
    .in_grad_y      (in_grad_y),
    .in_line_dx     (in_line_dx),
    .in_line_dy     (in_line_dy),
    .in_last_sample (in_last_sample),
    .min_gradient   (min_gradient_r),
    .rec_valid      (fr_valid),
    .rec            (fr_rec),
    .rec_ready      (!q_full)
  );

  // Short queue of finished line records between the two halves.
  lgsc_queue #(.W(REC_W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fr_valid),
    .din       (fr_rec),
    .full      (q_full),
    .pop       (bk_pop),
    .dout      (q_dout),
    .not_empty (q_not_empty)
  );

  // Back: ratio test, then a bitwise search for the rounded mean done on
  // squares with a shared serial multiplier, so no square root or divide.
  lgsc_back #(
    .CNT_W (CNT_W),
    .D2_W  (D2_W),
    .REC_W (REC_W)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .rec_valid     (q_not_empty),
    .rec           (q_dout),
    .rec_pop       (bk_pop),
    .max_low_ratio (max_low_ratio_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_res       (res)
  );

  assign out_mean_gradient = res.mean;
  assign out_accepted      = res.accepted;
  assign out_zero_length   = res.zero_length;
  assign out_samples_seen  = res.seen;

endmodule
